@@ sv/fcrc_pkg.sv @@
package fcrc_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 12;
    localparam int INDEX_W   = 11;
    localparam int CRC_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CRC_W-1:0]  CRC_INIT      = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY      = 16'hA001;
    localparam logic [CRC_W-1:0]  PAYLOAD_LIMIT = 16'd2048;

    localparam logic [BYTE_W-1:0] START_RESET   = 8'hA5;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 12'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'b1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD_CRC = 2'd2
    } t_kind;

endpackage

@@ sv/fcrc_rx_if.sv @@
interface fcrc_rx_if;
    logic                         valid;
    logic                         ready;
    logic [fcrc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/fcrc_res_if.sv @@
interface fcrc_res_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [fcrc_pkg::BYTE_W-1:0]  data_byte;
    logic [fcrc_pkg::INDEX_W-1:0] byte_index;
    logic [fcrc_pkg::BYTE_W-1:0]  command;
    logic [fcrc_pkg::BYTE_W-1:0]  sequence_res;
    logic [fcrc_pkg::LEN_W-1:0]   announced_len;
    logic [fcrc_pkg::CRC_W-1:0]   received_crc;
    logic [fcrc_pkg::CRC_W-1:0]   computed_crc;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output command, output sequence_res, output announced_len,
                    output received_crc, output computed_crc, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input command, input sequence_res, input announced_len,
                    input received_crc, input computed_crc, output ready);
endinterface

@@ sv/fcrc_crc_byte.sv @@
module fcrc_crc_byte (
    input  logic [fcrc_pkg::CRC_W-1:0]  i_crc,
    input  logic [fcrc_pkg::BYTE_W-1:0] i_byte,
    output logic [fcrc_pkg::CRC_W-1:0]  o_crc
);

    logic [fcrc_pkg::CRC_W-1:0] crc;

    always_comb begin
        crc = i_crc ^ {{(fcrc_pkg::CRC_W-fcrc_pkg::BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < fcrc_pkg::BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ fcrc_pkg::CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        o_crc = crc;
    end

endmodule

@@ sv/framed_command_receiver_crc16.sv @@
// Channel   Dir  Width  Contents
// i_rx      in   8      received byte (rx_byte)
// o_res     out  81     payload word or end-of-frame verdict
// i_cfg_*   in   1+12   register write: start byte, maximum payload length
//
// One byte is accepted per cycle unless stalled; its result, if any, is registered.
// The output register parts the sides: i_rx.ready is low only while a result is held
// and o_res.ready is low. The parser state and CRC update in the same cycle.
// Synchronous active-low reset returns the parser to hunting for the start byte.
module framed_command_receiver_crc16 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fcrc_rx_if.sink                           i_rx,
    fcrc_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [fcrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fcrc_pkg::LEN_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_CMD, PH_SEQ, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [fcrc_pkg::BYTE_W-1:0]     r_start_byte;
    logic [fcrc_pkg::LEN_W-1:0]      r_max_len;
    logic [fcrc_pkg::BYTE_W-1:0]     r_len_lo, n_len_lo;
    logic [fcrc_pkg::LEN_W-1:0]      r_exp_len, n_exp_len;
    logic [fcrc_pkg::LEN_W-1:0]      r_count, n_count;
    logic [fcrc_pkg::BYTE_W-1:0]     r_cmd, n_cmd;
    logic [fcrc_pkg::BYTE_W-1:0]     r_seq, n_seq;
    logic [fcrc_pkg::CRC_W-1:0]      r_crc, n_crc;
    logic [fcrc_pkg::BYTE_W-1:0]     r_crc_lo, n_crc_lo;

    logic                            r_out_valid;
    fcrc_pkg::t_kind                 r_kind, n_kind;
    logic [fcrc_pkg::BYTE_W-1:0]     r_data, n_data;
    logic [fcrc_pkg::INDEX_W-1:0]    r_index, n_index;
    logic [fcrc_pkg::BYTE_W-1:0]     r_out_cmd, n_out_cmd;
    logic [fcrc_pkg::BYTE_W-1:0]     r_out_seq, n_out_seq;
    logic [fcrc_pkg::LEN_W-1:0]      r_out_len, n_out_len;
    logic [fcrc_pkg::CRC_W-1:0]      r_rcrc, n_rcrc;
    logic [fcrc_pkg::CRC_W-1:0]      r_ccrc, n_ccrc;
    logic                            n_emit;

    logic                            accept;
    logic [fcrc_pkg::BYTE_W-1:0]     rx;
    logic [fcrc_pkg::CRC_W-1:0]      crc_in, crc_out;
    logic [fcrc_pkg::CRC_W-1:0]      frame_len, len_limit, frame_crc;
    logic [fcrc_pkg::LEN_W:0]        count_inc;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign rx         = i_rx.rx_byte;

    assign crc_in    = (r_phase == PH_HUNT) ? fcrc_pkg::CRC_INIT : r_crc;
    assign frame_len = {rx, r_len_lo};
    assign frame_crc = {rx, r_crc_lo};
    assign len_limit = ({4'd0, r_max_len} > fcrc_pkg::PAYLOAD_LIMIT) ?
                       fcrc_pkg::PAYLOAD_LIMIT : {4'd0, r_max_len};
    assign count_inc = {1'b0, r_count} + 13'd1;

    fcrc_crc_byte u_crc (
        .i_crc  (crc_in),
        .i_byte (rx),
        .o_crc  (crc_out)
    );

    always_comb begin
        n_phase   = r_phase;
        n_len_lo  = r_len_lo;
        n_exp_len = r_exp_len;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_seq     = r_seq;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        n_emit    = 1'b0;
        n_kind    = fcrc_pkg::KIND_PAYLOAD;
        n_data    = '0;
        n_index   = '0;
        n_out_cmd = r_cmd;
        n_out_seq = r_seq;
        n_out_len = r_exp_len;
        n_rcrc    = '0;
        n_ccrc    = '0;
        case (r_phase)
            PH_HUNT: begin
                if (rx == r_start_byte) begin
                    n_crc   = crc_out;
                    n_count = '0;
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                n_crc    = crc_out;
                n_len_lo = rx;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_crc = crc_out;
                if (frame_len > len_limit) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_exp_len = frame_len[fcrc_pkg::LEN_W-1:0];
                    n_phase   = PH_CMD;
                end
            end
            PH_CMD: begin
                n_crc   = crc_out;
                n_cmd   = rx;
                n_phase = PH_SEQ;
            end
            PH_SEQ: begin
                n_crc   = crc_out;
                n_seq   = rx;
                n_count = '0;
                n_phase = (r_exp_len == '0) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc   = crc_out;
                n_emit  = 1'b1;
                n_data  = rx;
                n_index = r_count[fcrc_pkg::INDEX_W-1:0];
                n_count = count_inc[fcrc_pkg::LEN_W-1:0];
                if (count_inc >= {1'b0, r_exp_len}) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = rx;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_emit  = 1'b1;
                n_kind  = (frame_crc == r_crc) ? fcrc_pkg::KIND_GOOD : fcrc_pkg::KIND_BAD_CRC;
                n_rcrc  = frame_crc;
                n_ccrc  = r_crc;
                n_count = '0;
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= fcrc_pkg::START_RESET;
            r_max_len    <= fcrc_pkg::MAX_LEN_RESET;
            r_phase      <= PH_HUNT;
            r_len_lo     <= '0;
            r_exp_len    <= '0;
            r_count      <= '0;
            r_cmd        <= '0;
            r_seq        <= '0;
            r_crc        <= fcrc_pkg::CRC_INIT;
            r_crc_lo     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fcrc_pkg::CFG_START_BYTE: r_start_byte <= i_cfg_data[fcrc_pkg::BYTE_W-1:0];
                    fcrc_pkg::CFG_MAX_LEN:    r_max_len    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_len_lo <= n_len_lo;
                r_exp_len <= n_exp_len;
                r_count  <= n_count;
                r_cmd    <= n_cmd;
                r_seq    <= n_seq;
                r_crc    <= n_crc;
                r_crc_lo <= n_crc_lo;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
                r_kind      <= n_kind;
                r_data      <= n_data;
                r_index     <= n_index;
                r_out_cmd   <= n_out_cmd;
                r_out_seq   <= n_out_seq;
                r_out_len   <= n_out_len;
                r_rcrc      <= n_rcrc;
                r_ccrc      <= n_ccrc;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_kind;
    assign o_res.data_byte     = r_data;
    assign o_res.byte_index    = r_index;
    assign o_res.command       = r_out_cmd;
    assign o_res.sequence_res  = r_out_seq;
    assign o_res.announced_len = r_out_len;
    assign o_res.received_crc  = r_rcrc;
    assign o_res.computed_crc  = r_ccrc;

endmodule

@@ sv/fcrc_checker.sv @@
module fcrc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               i_ready,
    input logic [1:0]                         i_kind,
    input logic [fcrc_pkg::BYTE_W-1:0]        i_data_byte,
    input logic [fcrc_pkg::INDEX_W-1:0]       i_byte_index,
    input logic [fcrc_pkg::LEN_W-1:0]         i_announced_len,
    input logic [fcrc_pkg::CRC_W-1:0]         i_received_crc,
    input logic [fcrc_pkg::CRC_W-1:0]         i_computed_crc
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result word dropped while stalled");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_kind == fcrc_pkg::KIND_PAYLOAD || i_kind == fcrc_pkg::KIND_GOOD ||
                     i_kind == fcrc_pkg::KIND_BAD_CRC))
        else $error("undefined result kind");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == fcrc_pkg::KIND_PAYLOAD |->
        i_received_crc == '0 && i_computed_crc == '0 &&
        {1'b0, i_byte_index} < i_announced_len)
        else $error("payload word fields inconsistent");

    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != fcrc_pkg::KIND_PAYLOAD |->
        i_data_byte == '0 && i_byte_index == '0 &&
        ((i_kind == fcrc_pkg::KIND_GOOD) == (i_received_crc == i_computed_crc)))
        else $error("verdict disagrees with CRC values");

endmodule

bind framed_command_receiver_crc16 fcrc_checker u_fcrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_kind          (o_res.kind),
    .i_data_byte     (o_res.data_byte),
    .i_byte_index    (o_res.byte_index),
    .i_announced_len (o_res.announced_len),
    .i_received_crc  (o_res.received_crc),
    .i_computed_crc  (o_res.computed_crc)
);
